FILE: sv/sht_pkg.sv
`default_nettype none
package sht_pkg;
  localparam int DEPTH_DEF = 1024;
  localparam int NUM_TABLES_DEF = 3;
  localparam int ID_BITS_DEF = 20;
  localparam int MAX_CAND_DEF = 64;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_FIND    = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_TABLE = 3'd3;
  localparam logic [2:0] ST_CAND      = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  table_sel;
    logic [19:0] entry_id;
    logic [31:0] key_hash;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] cand_id;
    logic [10:0] position;
    logic [10:0] entry_count;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_EV, S_BACK_RD, S_BACK_EV,
    S_SCAN_RD, S_SCAN_EV, S_LOOK_RD, S_SHIFT_RD, S_SHIFT_WR, S_EMIT, S_WAIT
  } state_t;

  // datapath commands
  typedef struct packed {
    logic load;       // capture input item and start search window
    logic rd_mid;     // read at search probe
    logic srch_step;  // evaluate probe
    logic rd_prev;    // read pos-1
    logic back_step;  // evaluate pos-1
    logic rd_pos;     // read at pos
    logic scan_step;  // evaluate run entry at pos
    logic cap_id;     // latch candidate id read at pos
    logic rd_next;    // read pos+1 to see whether the run goes on
    logic shift_rd;   // read source of shift
    logic shift_wr;   // write shift destination
    logic ins_wr;     // write new pair at pos
    logic cnt_inc;
    logic cnt_dec;
    logic emit;       // load output register
    logic [2:0] st;
    logic use_pos;    // position from pos, else zero
    logic use_id;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic bad_table;
    logic full;
    logic srch_done;
    logic hit;
    logic back_more;   // pos>0 and h[pos-1]==key
    logic in_run;      // pos<n and rd hash == key
    logic id_match;
    logic more;        // pos+1<n and h[pos+1]==key
    logic trunc;       // candidate count reached max-1
    logic shift_done;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

FILE: sv/sht_datapath.sv
`default_nettype none
module sht_datapath #(
  parameter int DEPTH = sht_pkg::DEPTH_DEF,
  parameter int NUM_TABLES = sht_pkg::NUM_TABLES_DEF,
  parameter int ID_BITS = sht_pkg::ID_BITS_DEF,
  parameter int MAX_CANDIDATES = sht_pkg::MAX_CAND_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sht_pkg::in_item_t in_item,
  input  wire sht_pkg::cmd_t cmd,
  output sht_pkg::stat_t stat,
  output sht_pkg::out_item_t out_item,
  output logic out_valid,
  input  wire logic out_ready
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int AW = $clog2(NUM_TABLES * DEPTH);
  localparam int KW = $clog2(MAX_CANDIDATES + 1);
  localparam int IW = (ID_BITS < 20) ? ID_BITS : 20;

  logic [32+IW-1:0] mem [NUM_TABLES*DEPTH];
  logic [CW-1:0] counts [NUM_TABLES];

  logic [1:0] op;
  logic [TW-1:0] sel;
  logic [IW-1:0] id;
  logic [31:0] key;
  logic [CW-1:0] n;
  logic [CW-1:0] base, size, pos, src;
  logic [KW-1:0] k;
  logic [31:0] rd_h;
  logic [IW-1:0] rd_id;
  logic [IW-1:0] cand;
  logic hit;
  logic bad_sel;

  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] rd_idx, wr_idx, probe;
  logic [32+IW-1:0] wr_data;
  logic wr_en, rd_en;

  logic bad;
  assign bad = 32'(in_item.table_sel) >= 32'(NUM_TABLES);
  assign probe = base + (size >> 1);

  always_comb begin
    rd_en = 1'b1;
    rd_idx = probe;
    if (cmd.rd_prev) rd_idx = pos - 1'b1;
    else if (cmd.rd_pos) rd_idx = pos;
    else if (cmd.rd_next) rd_idx = pos + 1'b1;
    else if (cmd.shift_rd) rd_idx = src;
    else if (!cmd.rd_mid) rd_en = 1'b0;
    rd_addr = AW'(32'(sel) * DEPTH + 32'(rd_idx[PW-1:0]));
    wr_en = cmd.shift_wr | cmd.ins_wr;
    wr_idx = (op == sht_pkg::CMD_INSERT) ? src + 1'b1 : src - 1'b1;
    wr_data = {rd_h, rd_id};
    if (cmd.ins_wr) begin
      wr_idx = pos;
      wr_data = {key, id};
    end
    wr_addr = AW'(32'(sel) * DEPTH + 32'(wr_idx[PW-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rd_en) {rd_h, rd_id} <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TABLES; i++) counts[i] <= '0;
    end else if (cmd.cnt_inc) begin
      counts[sel] <= n + 1'b1;
    end else if (cmd.cnt_dec) begin
      counts[sel] <= n - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_item.cmd;
      sel <= TW'(in_item.table_sel);
      id <= in_item.entry_id[IW-1:0];
      key <= in_item.key_hash;
      bad_sel <= bad;
      n <= bad ? '0 : counts[TW'(in_item.table_sel)];
      base <= '0;
      size <= bad ? '0 : counts[TW'(in_item.table_sel)];
      pos <= '0;
      hit <= 1'b0;
      k <= '0;
    end
    if (cmd.srch_step) begin
      pos <= probe;
      if (key == rd_h) begin
        hit <= 1'b1;
        size <= '0;
      end else if (size == CW'(1)) begin
        if (key > rd_h) pos <= probe + 1'b1;
        size <= '0;
      end else if (key < rd_h) begin
        size <= size >> 1;
      end else begin
        base <= probe;
        size <= size - (size >> 1);
      end
    end
    if (cmd.back_step && stat.back_more) pos <= pos - 1'b1;
    if (cmd.scan_step && !stat.id_match) pos <= pos + 1'b1;
    if (cmd.cap_id) cand <= rd_id;
    if (cmd.emit && cmd.use_id && !cmd.last) begin
      pos <= pos + 1'b1;
      k <= k + 1'b1;
    end
    // shift pointer: insert walks down from the top, remove walks up
    if (cmd.shift_wr) src <= (op == sht_pkg::CMD_INSERT) ? src - 1'b1 : src + 1'b1;
    else if (!cmd.shift_rd) src <= (op == sht_pkg::CMD_INSERT) ? n - 1'b1 : pos + 1'b1;
  end

  assign stat.bad_table = bad_sel;
  assign stat.full = n >= CW'(DEPTH);
  assign stat.srch_done = (size == '0);
  assign stat.hit = hit;
  assign stat.back_more = (pos != '0) && (rd_h == key);
  assign stat.in_run = (pos < n) && (rd_h == key);
  assign stat.id_match = rd_id == id;
  assign stat.more = ((pos + 1'b1) < n) && (rd_h == key);
  assign stat.trunc = 32'(k) == MAX_CANDIDATES - 1;
  assign stat.shift_done = (op == sht_pkg::CMD_INSERT) ? (src < pos || src == '1)
                                                       : (src >= n);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.status <= cmd.st;
      out_item.cand_id <= cmd.use_id ? 20'(cand) : '0;
      out_item.position <= cmd.use_pos ? 11'(pos) : '0;
      out_item.entry_count <= cmd.cnt_inc ? 11'(n + 1'b1) :
                              cmd.cnt_dec ? 11'(n - 1'b1) : 11'(n);
      out_item.last <= cmd.last;
    end
  end
endmodule
`default_nettype wire

FILE: sv/sht_ctrl.sv
`default_nettype none
module sht_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] op_in,
  input  wire sht_pkg::stat_t stat,
  output sht_pkg::cmd_t cmd
);
  sht_pkg::state_t state, state_next;
  logic [1:0] op, op_next;
  logic found, found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sht_pkg::S_IDLE;
      op <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      op <= op_next;
      found <= found_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    op_next = op;
    found_next = found;
    in_ready = 1'b0;
    unique case (state)
      sht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          op_next = op_in;
          found_next = 1'b0;
          state_next = sht_pkg::S_SRCH_RD;
        end
      end
      sht_pkg::S_SRCH_RD: begin
        if (stat.srch_done) state_next = sht_pkg::S_WAIT;
        else begin
          cmd.rd_mid = 1'b1;
          state_next = sht_pkg::S_SRCH_EV;
        end
      end
      sht_pkg::S_SRCH_EV: begin
        cmd.srch_step = 1'b1;
        state_next = sht_pkg::S_SRCH_RD;
      end
      sht_pkg::S_BACK_RD: begin
        cmd.rd_prev = 1'b1;
        state_next = sht_pkg::S_BACK_EV;
      end
      sht_pkg::S_BACK_EV: begin
        cmd.back_step = 1'b1;
        state_next = stat.back_more ? sht_pkg::S_BACK_RD : sht_pkg::S_SCAN_RD;
      end
      sht_pkg::S_SCAN_RD: begin
        cmd.rd_pos = 1'b1;
        state_next = sht_pkg::S_SCAN_EV;
      end
      sht_pkg::S_SCAN_EV: begin
        if (op == sht_pkg::CMD_FIND) begin
          cmd.cap_id = 1'b1;
          state_next = sht_pkg::S_LOOK_RD;
        end else if (!stat.in_run) begin
          state_next = sht_pkg::S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.id_match) begin
            found_next = 1'b1;
            state_next = sht_pkg::S_SHIFT_RD;
          end else begin
            state_next = sht_pkg::S_SCAN_RD;
          end
        end
      end
      sht_pkg::S_LOOK_RD: begin
        // peek at the next entry so the candidate knows whether it is the last
        cmd.rd_next = 1'b1;
        state_next = sht_pkg::S_EMIT;
      end
      sht_pkg::S_SHIFT_RD: begin
        if (stat.shift_done) begin
          if (op == sht_pkg::CMD_INSERT) cmd.ins_wr = 1'b1;
          state_next = sht_pkg::S_EMIT;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next = sht_pkg::S_SHIFT_WR;
        end
      end
      sht_pkg::S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_next = sht_pkg::S_SHIFT_RD;
      end
      sht_pkg::S_EMIT: begin
        // result for insert/remove done, remove miss, or one find candidate
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.use_pos = 1'b1;
          cmd.last = 1'b1;
          state_next = sht_pkg::S_IDLE;
          if (op == sht_pkg::CMD_INSERT) begin
            cmd.cnt_inc = 1'b1;
          end else if (op == sht_pkg::CMD_REMOVE) begin
            if (found) cmd.cnt_dec = 1'b1;
            else cmd.st = sht_pkg::ST_NOT_FOUND;
            cmd.use_pos = found;
          end else begin
            cmd.use_id = 1'b1;
            cmd.st = sht_pkg::ST_CAND;
            if (stat.more) begin
              // run goes on: stop here at the limit, else advance to the next entry
              if (stat.trunc) begin
                cmd.st = sht_pkg::ST_TRUNC;
              end else begin
                cmd.last = 1'b0;
                state_next = sht_pkg::S_SCAN_RD;
              end
            end
          end
        end
      end
      sht_pkg::S_WAIT: begin
        // search over: decide
        if (stat.out_free) begin
          state_next = sht_pkg::S_IDLE;
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          if (stat.bad_table || op == sht_pkg::CMD_UNKNOWN) cmd.st = sht_pkg::ST_BAD_TABLE;
          else if (op == sht_pkg::CMD_INSERT) begin
            if (stat.full) cmd.st = sht_pkg::ST_FULL;
            else begin
              cmd.emit = 1'b0;
              state_next = sht_pkg::S_SHIFT_RD;
            end
          end else if (!stat.hit) cmd.st = sht_pkg::ST_NOT_FOUND;
          else begin
            cmd.emit = 1'b0;
            state_next = sht_pkg::S_BACK_RD;
          end
        end
      end
      default: state_next = sht_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/sorted_hash_table_engine.sv
`default_nettype none
// Channel | Direction | Payload                 | Handshake
// in      | input     | sht_pkg::in_item_t      | in_valid / in_ready
// out     | output    | sht_pkg::out_item_t     | out_valid / out_ready
//
// One item at a time. Search: each halving step reads the probe, then evaluates it.
// Insert then shifts entries up one at a time, reading each and writing it back one
// slot higher. Remove walks back to the run start, scans for the id and shifts down,
// reading and then evaluating or writing each entry in each phase. Find walks back
// the same way, then takes four steps per candidate (read, latch id, read next, emit).
// Reset clears the counts, out_valid and the controller state, not the table memory;
// stalls on out hold the engine in its emit or wait state.
module sorted_hash_table_engine #(
  parameter int DEPTH = sht_pkg::DEPTH_DEF,
  parameter int NUM_TABLES = sht_pkg::NUM_TABLES_DEF,
  parameter int ID_BITS = sht_pkg::ID_BITS_DEF,
  parameter int MAX_CANDIDATES = sht_pkg::MAX_CAND_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire sht_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output sht_pkg::out_item_t out_data
);
  sht_pkg::cmd_t cmd;
  sht_pkg::stat_t stat;

  // controller sequences search, run scan, shift and emit
  sht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op_in(in_data.cmd), .stat(stat), .cmd(cmd)
  );

  // datapath holds the table memory, counts and output register
  sht_datapath #(
    .DEPTH(DEPTH), .NUM_TABLES(NUM_TABLES), .ID_BITS(ID_BITS),
    .MAX_CANDIDATES(MAX_CANDIDATES)
  ) u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd), .stat(stat),
    .out_item(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule
`default_nettype wire

FILE: sim/sorted_hash_table_engine_test.sv
`default_nettype none
module sorted_hash_table_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = sht_pkg::DEPTH_DEF;
  localparam int NTAB = sht_pkg::NUM_TABLES_DEF;
  localparam int MAXC = sht_pkg::MAX_CAND_DEF;
  localparam longint CYCLE_LIMIT = 64'd4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sht_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sht_pkg::out_item_t out_data;

  sorted_hash_table_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the tables: hash and id per slot, plus live counts.
  logic [31:0] tbl_hash [NTAB][DEPTH];
  logic [19:0] tbl_id [NTAB][DEPTH];
  int unsigned tbl_count [NTAB];

  sht_pkg::out_item_t pending_results [$];
  int errors = 0;
  longint cycles = 0;
  bit rx_idle_ok = 1'b1;   // random stalls on the receive side
  bit tx_idle_ok = 1'b1;   // random gaps on the send side
  int hold_off = 0;        // long receiver hold-off, counted down per cycle

  function automatic sht_pkg::out_item_t mk(logic [2:0] st, logic [19:0] id,
                                            int unsigned pos, int unsigned cnt, bit lst);
    sht_pkg::out_item_t r;
    r.status = st;
    r.cand_id = id;
    r.position = pos[10:0];
    r.entry_count = cnt[10:0];
    r.last = lst;
    return r;
  endfunction

  // Halving search over the first n entries; mirrors the block's probe order.
  function automatic bit locate(int t, int unsigned n, logic [31:0] key,
                                output int unsigned pos);
    int unsigned base, size, mid, probe;
    base = 0;
    size = n;
    probe = 0;
    while (size > 0) begin
      mid = size / 2;
      probe = base + mid;
      if (key == tbl_hash[t][probe]) begin
        pos = probe;
        return 1'b1;
      end
      if (size == 1) begin
        if (key > tbl_hash[t][probe]) probe++;
        break;
      end
      if (key < tbl_hash[t][probe]) size = mid;
      else begin
        base = probe;
        size -= mid;
      end
    end
    pos = probe;
    return 1'b0;
  endfunction

  // Apply one item to the shadow tables and queue what it must produce.
  task automatic predict_table_op(sht_pkg::in_item_t it);
    int t;
    int unsigned n, pos, k;
    bit hit, more;
    t = it.table_sel;
    if (t >= NTAB) begin
      pending_results.push_back(mk(sht_pkg::ST_BAD_TABLE, 0, 0, 0, 1));
      return;
    end
    n = tbl_count[t];
    hit = locate(t, n, it.key_hash, pos);
    if (it.cmd == sht_pkg::CMD_INSERT) begin
      if (n >= DEPTH) begin
        pending_results.push_back(mk(sht_pkg::ST_FULL, 0, 0, n, 1));
        return;
      end
      for (int i = n; i > pos; i--) begin
        tbl_hash[t][i] = tbl_hash[t][i-1];
        tbl_id[t][i] = tbl_id[t][i-1];
      end
      tbl_hash[t][pos] = it.key_hash;
      tbl_id[t][pos] = it.entry_id;
      tbl_count[t] = n + 1;
      pending_results.push_back(mk(sht_pkg::ST_DONE, 0, pos, n + 1, 1));
      return;
    end
    if (it.cmd == sht_pkg::CMD_UNKNOWN) begin
      pending_results.push_back(mk(sht_pkg::ST_BAD_TABLE, 0, 0, n, 1));
      return;
    end
    if (!hit) begin
      pending_results.push_back(mk(sht_pkg::ST_NOT_FOUND, 0, 0, n, 1));
      return;
    end
    while (pos > 0 && tbl_hash[t][pos-1] == it.key_hash) pos--;
    if (it.cmd == sht_pkg::CMD_REMOVE) begin
      for (; pos < n && tbl_hash[t][pos] == it.key_hash; pos++) begin
        if (tbl_id[t][pos] == it.entry_id) begin
          for (int i = pos; i + 1 < n; i++) begin
            tbl_hash[t][i] = tbl_hash[t][i+1];
            tbl_id[t][i] = tbl_id[t][i+1];
          end
          tbl_count[t] = n - 1;
          pending_results.push_back(mk(sht_pkg::ST_DONE, 0, pos, n - 1, 1));
          return;
        end
      end
      pending_results.push_back(mk(sht_pkg::ST_NOT_FOUND, 0, 0, n, 1));
      return;
    end
    k = 0;
    for (; pos < n && tbl_hash[t][pos] == it.key_hash; pos++) begin
      more = (pos + 1 < n) && (tbl_hash[t][pos+1] == it.key_hash);
      if (k == MAXC - 1 && more) begin
        pending_results.push_back(mk(sht_pkg::ST_TRUNC, tbl_id[t][pos], pos, n, 1));
        return;
      end
      pending_results.push_back(mk(sht_pkg::ST_CAND, tbl_id[t][pos], pos, n, !more));
      k++;
      if (!more) break;
    end
  endtask

  // Offer one item at the falling edge and hold it until accepted; the next
  // call (or the drain) replaces or drops it at the following falling edge.
  task automatic send_item(logic [1:0] cmd, logic [1:0] sel, logic [19:0] id,
                           logic [31:0] key);
    sht_pkg::in_item_t it;
    it.cmd = cmd;
    it.table_sel = sel;
    it.entry_id = id;
    it.key_hash = key;
    if (tx_idle_ok && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table_op(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Receiver readiness: random stall bursts, plus an optional long hold-off.
  initial begin
    int burst;
    burst = 0;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else if (burst > 0) begin
        out_ready <= 1'b0;
        burst--;
      end else if (rx_idle_ok && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  initial begin
    sht_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result %p", out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.cand_id !== want.cand_id) begin
            $error("cand_id exp %0h got %0h", want.cand_id, out_data.cand_id);
            errors++;
          end
          if (out_data.position !== want.position) begin
            $error("position exp %0d got %0d", want.position, out_data.position);
            errors++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count exp %0d got %0d", want.entry_count, out_data.entry_count);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, out_data.last);
            errors++;
          end
        end
      end
    end
  end

  // Boundary keys and ids, bad table, unknown command, misses.
  task automatic test_directed_edges();
    send_item(sht_pkg::CMD_FIND, 2'd0, 20'd0, 32'd5);            // find in empty table
    send_item(sht_pkg::CMD_REMOVE, 2'd0, 20'd1, 32'd5);          // remove from empty table
    send_item(sht_pkg::CMD_INSERT, 2'd0, 20'hFFFFF, 32'hFFFFFFFF);
    send_item(sht_pkg::CMD_INSERT, 2'd0, 20'd0, 32'd0);
    send_item(sht_pkg::CMD_INSERT, 2'd0, 20'h5A5A5, 32'h8000_0000);
    send_item(sht_pkg::CMD_INSERT, 2'd0, 20'hA5A5A, 32'h8000_0000);  // equal hash
    send_item(sht_pkg::CMD_FIND, 2'd0, 20'd0, 32'h8000_0000);
    send_item(sht_pkg::CMD_FIND, 2'd0, 20'd0, 32'h7FFF_FFFF);        // miss between
    send_item(sht_pkg::CMD_REMOVE, 2'd0, 20'h12345, 32'h8000_0000);  // id miss in run
    send_item(sht_pkg::CMD_REMOVE, 2'd0, 20'hA5A5A, 32'h8000_0000);
    send_item(sht_pkg::CMD_REMOVE, 2'd0, 20'hFFFFF, 32'hFFFFFFFF);
    send_item(sht_pkg::CMD_INSERT, 2'd3, 20'hFFFFF, 32'hFFFFFFFF);   // bad table
    send_item(sht_pkg::CMD_FIND, 2'd3, 20'd0, 32'd0);
    send_item(sht_pkg::CMD_UNKNOWN, 2'd0, 20'd7, 32'd0);             // unknown command
    send_item(sht_pkg::CMD_UNKNOWN, 2'd3, 20'd7, 32'd0);
    send_item(sht_pkg::CMD_INSERT, 2'd1, 20'd3, 32'h1234_5678);
    send_item(sht_pkg::CMD_INSERT, 2'd2, 20'd4, 32'h0000_0001);
    send_item(sht_pkg::CMD_FIND, 2'd1, 20'd0, 32'h1234_5678);
    send_item(sht_pkg::CMD_FIND, 2'd2, 20'd0, 32'h0000_0001);
    wait_drained();
  endtask

  // Long equal-hash run in table 2 so find truncates past the candidate limit.
  task automatic test_long_run_truncation();
    for (int i = 0; i < MAXC + 2; i++)
      send_item(sht_pkg::CMD_INSERT, 2'd2, 20'(i * 7 + 1), 32'hCAFE_0000);
    send_item(sht_pkg::CMD_FIND, 2'd2, 20'd0, 32'hCAFE_0000);
    // drop to exactly the limit, then find again without truncation
    send_item(sht_pkg::CMD_REMOVE, 2'd2, 20'd1, 32'hCAFE_0000);
    send_item(sht_pkg::CMD_REMOVE, 2'd2, 20'd8, 32'hCAFE_0000);
    send_item(sht_pkg::CMD_FIND, 2'd2, 20'd0, 32'hCAFE_0000);
    wait_drained();
  endtask

  // Hold the receiver off while finds pile up, then stall the sender until drained.
  task automatic test_backpressure();
    hold_off = 300;
    for (int i = 0; i < 6; i++)
      send_item(sht_pkg::CMD_FIND, 2'd2, 20'd0, 32'hCAFE_0000);
    wait_drained();
  endtask

  // Random mix over a small key space so runs, hits and removes of real ids occur.
  task automatic test_random_mix(int count);
    logic [31:0] key;
    logic [19:0] id;
    logic [1:0] cmd, sel;
    int t;
    int unsigned slot;
    for (int i = 0; i < count; i++) begin
      sel = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: cmd = sht_pkg::CMD_UNKNOWN;
        1, 2, 3, 4, 5, 6, 7, 8: cmd = sht_pkg::CMD_INSERT;
        9, 10, 11, 12, 13: cmd = sht_pkg::CMD_REMOVE;
        default: cmd = sht_pkg::CMD_FIND;
      endcase
      key = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 15)) << 28;
      id = 20'($urandom());
      t = sel;
      // reuse a stored pair half the time so removes and finds hit
      if (t < NTAB && tbl_count[t] > 0 && cmd != sht_pkg::CMD_INSERT &&
          $urandom_range(0, 1)) begin
        slot = $urandom_range(0, tbl_count[t] - 1);
        key = tbl_hash[t][slot];
        id = tbl_id[t][slot];
      end
      send_item(cmd, sel, id, key);
    end
    wait_drained();
  endtask

  initial begin
    for (int t = 0; t < NTAB; t++) tbl_count[t] = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_edges();
    test_long_run_truncation();
    test_backpressure();
    test_random_mix(80);
    // quiet tail: no idling on either side
    rx_idle_ok = 1'b0;
    tx_idle_ok = 1'b0;
    test_random_mix(40);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
sv/sht_pkg.sv
sv/sht_datapath.sv
sv/sht_ctrl.sv
sv/sorted_hash_table_engine.sv
sim/sorted_hash_table_engine_test.sv
